FILE: rtl/core/bd_pkg.sv
// ---------------------------------------------------------------------------
// bd_pkg - shared types and constants of the bilinear downscaler
// Sequencer states, configuration register indexes and fixed widths.
// ---------------------------------------------------------------------------
package bd_pkg;

   // fixed field widths
   localparam int DIM_W    = 13;          // size registers
   localparam int INV_W    = 24;          // Q8.16 inverse scale
   localparam int CHC_W    = 3;           // channel count
   localparam int POS_W    = 12;          // output position fields
   localparam int PIX_W    = 32;          // four packed 8-bit channels
   localparam int ACC_W    = 32;          // Q16.16 coordinate accumulators
   localparam int IDX_W    = 16;          // integer part of a coordinate
   localparam int CSR_IDX_W = 3;

   localparam logic [DIM_W-1:0] OUT_LIMIT = 13'd4096;
   localparam logic [INV_W-1:0] UNITY     = 24'd65536;
   localparam logic [ACC_W-1:0] HALF      = 32'd32768;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INV_SCALE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CHAN_COUNT = 3'd5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MAP,
      S_HORZ,
      S_VERT
   } state_type;

   // source indices of one output coordinate
   typedef struct packed {
      logic [IDX_W-1:0] i0;
      logic [IDX_W-1:0] i1;
   } axis_type;

   // integer part and next index, both clamped to the last index
   function automatic axis_type map_axis(input logic [ACC_W-1:0] acc,
                                         input logic [IDX_W-1:0] last);
      axis_type         m;
      logic [IDX_W:0]   x0;
      logic [IDX_W:0]   x1;
      x0 = {1'b0, acc[ACC_W-1:16]};
      x1 = x0 + 1'b1;
      m.i0 = (x0 > {1'b0, last}) ? last : x0[IDX_W-1:0];
      m.i1 = (x1 > {1'b0, last}) ? last : x1[IDX_W-1:0];
      return m;
   endfunction

endpackage

FILE: rtl/core/bd_line_mem.sv
// ---------------------------------------------------------------------------
// bd_line_mem - previous-row line buffer
// One write port, one registered read port, one pixel per entry.
// ---------------------------------------------------------------------------
module bd_line_mem #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bd_blend.sv
// ---------------------------------------------------------------------------
// bd_blend - two-pass bilinear blend of four channels
// Horizontal pass is registered, vertical pass, rounding and saturation
// follow in the next cycle.
// ---------------------------------------------------------------------------
module bd_blend #(
   parameter int WEIGHT_BITS = 8
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [31:0]            p00,
   input  logic [31:0]            p01,
   input  logic [31:0]            p10,
   input  logic [31:0]            p11,
   input  logic [WEIGHT_BITS-1:0] tx,
   input  logic [WEIGHT_BITS-1:0] ty,
   output logic [3:0][7:0]        res
);

   localparam int VW = WEIGHT_BITS + 8;
   localparam int SW = 2 * WEIGHT_BITS + 9;
   localparam logic [WEIGHT_BITS:0] ONE = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;
   localparam logic [SW-1:0] RND = SW'(1) << (2 * WEIGHT_BITS - 1);

   logic [3:0][VW-1:0] v0_ff, v1_ff;
   logic [WEIGHT_BITS:0] wx0, wy0;

   assign wx0 = ONE - {1'b0, tx};
   assign wy0 = ONE - {1'b0, ty};

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [SW-1:0] s;
      logic [SW-1:0] q;

      // horizontal pass on both rows
      always_ff @(posedge clock) begin
         if (load) begin
            v0_ff[k] <= VW'(wx0 * p00[8*k +: 8] + tx * p01[8*k +: 8]);
            v1_ff[k] <= VW'(wx0 * p10[8*k +: 8] + tx * p11[8*k +: 8]);
         end
      end

      // vertical pass, round and saturate
      always_comb begin
         s = SW'(wy0 * v0_ff[k]) + SW'(ty * v1_ff[k]) + RND;
         q = s >> (2 * WEIGHT_BITS);
         res[k] = (q > SW'(255)) ? 8'hFF : q[7:0];
      end
   end

endmodule

FILE: rtl/core/bilinear_downscaler_unit.sv
// ---------------------------------------------------------------------------
// bilinear_downscaler_unit - streaming center-aligned bilinear downscaler
//
// Source pixels enter on req_* in raster order (valid/ready); req_frame_start
// restarts the frame at source (0,0). Output pixels leave on rsp_* with
// their output position; rsp_run_last closes the results of one source pixel
// and rsp_frame_last marks the final output of a frame. csr_* writes the
// size, scale and channel registers; a write to one of them restarts the
// frame position. Each source pixel passes a line buffer read, then
// coordinate mapping and state update, plus a horizontal and a vertical
// blend pass per output it produces; a pixel with no output ends after the
// mapping. The single line buffer port pair and the shared blend unit set
// this order, and no new pixel is accepted until all outputs of the last
// one are loaded; the first result follows the mapping and both blend passes.
// A stalled receiver holds the current result in the output register; the
// next item is still accepted while the last result of an item waits.
// Synchronous reset clears the registers to their reset values and restarts
// the frame; the line buffer itself is not cleared.
// ---------------------------------------------------------------------------
module bilinear_downscaler_unit #(
   parameter int MAX_WIDTH    = 4096,
   parameter int MAX_CHANNELS = 4,
   parameter int WEIGHT_BITS  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_chan0,
   input  logic [7:0]                  req_chan1,
   input  logic [7:0]                  req_chan2,
   input  logic [7:0]                  req_chan3,
   input  logic                        req_frame_start,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_res0,
   output logic [7:0]                  rsp_res1,
   output logic [7:0]                  rsp_res2,
   output logic [7:0]                  rsp_res3,
   output logic [bd_pkg::POS_W-1:0]    rsp_out_col,
   output logic [bd_pkg::POS_W-1:0]    rsp_out_row,
   output logic                        rsp_run_last,
   output logic                        rsp_frame_last,
   input  logic                        csr_we,
   input  logic [bd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bd_pkg::INV_W-1:0]    csr_wdata
);
   import bd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;
   localparam int WB = WEIGHT_BITS;

   // configuration registers
   logic [DIM_W-1:0] sw_ff, sh_ff, ow_ff, oh_ff;
   logic [INV_W-1:0] inv_ff;
   logic [CHC_W-1:0] cc_ff;

   // effective configuration
   logic [WW-1:0]    w;
   logic [DIM_W-1:0] h, ow, oh;
   logic [INV_W-1:0] inv;
   logic [CHC_W-1:0] ch;
   logic             unity;
   logic [ACC_W-1:0] start;

   // frame position
   logic [CW-1:0]    src_col_ff;
   logic [POS_W-1:0] src_row_ff;
   logic [DIM_W-1:0] dst_col_ff, dst_row_ff;
   logic [ACC_W-1:0] racc_ff, cacc_ff;
   logic [PIX_W-1:0] left_ff, aleft_ff, pix_ff;

   // per-item snapshot for emission
   logic             unity_q, ulast_q;
   logic [PIX_W-1:0] above_q, left_q, aleft_q;
   logic [DIM_W-1:0] dc_q, dr_q;
   logic [1:0]       nrows_q, ncols_q;
   logic [1:0][WB-1:0] tx_q, ty_q;
   logic [1:0]       srow_q, scol_q;
   logic [CW-1:0]    c_q;
   logic [POS_W-1:0] r_q;
   logic             a_ff, b_ff;

   state_type        state_ff, state_in;

   // output register
   logic             rsp_valid_ff;
   logic [3:0][7:0]  res_ff;
   logic [POS_W-1:0] col_ff, row_ff;
   logic             run_last_ff, frame_last_ff;

   logic             accept, restart_now;
   logic             mem_re, mem_we, blend_load, out_load, out_free, item_done;
   logic [CW-1:0]    rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic [PIX_W-1:0] req_pix;
   logic [PIX_W-1:0] p00, p01, p10, p11;
   logic [3:0][7:0]  blend_res;
   logic [3:0][7:0]  res_sel;

   axis_type         rm0, rm1, cm0, cm1;
   logic [ACC_W-1:0] rsum1, csum1;
   logic             rok0, rok1, cok0, cok1;
   logic [1:0]       nrows, ncols;

   // effective register values
   always_comb begin
      w = (sw_ff == '0) ? WW'(1)
          : ((32'(sw_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(sw_ff));
      h  = (sh_ff == '0) ? DIM_W'(1) : ((sh_ff > OUT_LIMIT) ? OUT_LIMIT : sh_ff);
      ow = (ow_ff == '0) ? DIM_W'(1) : ((ow_ff > OUT_LIMIT) ? OUT_LIMIT : ow_ff);
      oh = (oh_ff == '0) ? DIM_W'(1) : ((oh_ff > OUT_LIMIT) ? OUT_LIMIT : oh_ff);
      ch = (cc_ff == '0) ? CHC_W'(1)
           : ((32'(cc_ff) > MAX_CHANNELS) ? CHC_W'(MAX_CHANNELS) : cc_ff);
      inv   = (inv_ff < UNITY) ? UNITY : inv_ff;
      unity = (inv == UNITY);
      start = ACC_W'(inv >> 1) - HALF;
   end

   assign req_pix = {req_chan3, req_chan2, req_chan1, req_chan0};
   assign accept  = req_valid && req_ready;
   assign restart_now = req_frame_start || ({1'b0, src_col_ff} >= w)
                        || ({1'b0, src_row_ff} >= h);
   assign rd_addr = restart_now ? '0 : src_col_ff;

   // coordinate mapping for the current source pixel
   always_comb begin
      rsum1 = racc_ff + ACC_W'(inv);
      csum1 = cacc_ff + ACC_W'(inv);
      rm0 = map_axis(racc_ff, IDX_W'(h) - 1'b1);
      rm1 = map_axis(rsum1, IDX_W'(h) - 1'b1);
      cm0 = map_axis(cacc_ff, IDX_W'(w) - 1'b1);
      cm1 = map_axis(csum1, IDX_W'(w) - 1'b1);
      rok0 = (dst_row_ff < oh) && (rm0.i1 == IDX_W'(src_row_ff));
      rok1 = (14'(dst_row_ff) + 14'd1 < 14'(oh)) && (rm1.i1 == IDX_W'(src_row_ff));
      cok0 = (dst_col_ff < ow) && (cm0.i1 == IDX_W'(src_col_ff));
      cok1 = (14'(dst_col_ff) + 14'd1 < 14'(ow)) && (cm1.i1 == IDX_W'(src_col_ff));
      if (unity) begin
         nrows = 2'd0;
         ncols = 2'd0;
      end else begin
         nrows = rok0 ? (rok1 ? 2'd2 : 2'd1) : 2'd0;
         ncols = cok0 ? (cok1 ? 2'd2 : 2'd1) : 2'd0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_MAP;
         S_MAP: begin
            if (unity || (nrows != 2'd0 && ncols != 2'd0)) state_in = S_HORZ;
            else state_in = S_IDLE;
         end
         S_HORZ: state_in = S_VERT;
         S_VERT: begin
            if (out_free) state_in = item_done ? S_IDLE : S_HORZ;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = 1'b0;
      mem_re     = 1'b0;
      mem_we     = 1'b0;
      blend_load = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            mem_re    = accept;
         end
         S_MAP:  mem_we     = 1'b1;
         S_HORZ: blend_load = 1'b1;
         S_VERT: out_load   = out_free;
         default: ;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign item_done = unity_q || ((b_ff == ncols_q[0]) && (a_ff == nrows_q[0]));

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff  <= DIM_W'(1);
         sh_ff  <= DIM_W'(1);
         ow_ff  <= DIM_W'(1);
         oh_ff  <= DIM_W'(1);
         inv_ff <= UNITY;
         cc_ff  <= CHC_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_SRC_WIDTH:  sw_ff  <= csr_wdata[DIM_W-1:0];
            REG_SRC_HEIGHT: sh_ff  <= csr_wdata[DIM_W-1:0];
            REG_OUT_WIDTH:  ow_ff  <= csr_wdata[DIM_W-1:0];
            REG_OUT_HEIGHT: oh_ff  <= csr_wdata[DIM_W-1:0];
            REG_INV_SCALE:  inv_ff <= csr_wdata;
            REG_CHAN_COUNT: cc_ff  <= csr_wdata[CHC_W-1:0];
            default: ;
         endcase
      end
   end

   // the new start coordinate follows the register being written
   logic [INV_W-1:0] inv_new;
   logic [ACC_W-1:0] start_new;
   logic             csr_hit;
   always_comb begin
      csr_hit = (csr_index == REG_SRC_WIDTH) || (csr_index == REG_SRC_HEIGHT)
                || (csr_index == REG_OUT_WIDTH) || (csr_index == REG_OUT_HEIGHT)
                || (csr_index == REG_INV_SCALE) || (csr_index == REG_CHAN_COUNT);
      inv_new = (csr_index == REG_INV_SCALE) ? csr_wdata : inv_ff;
      if (inv_new < UNITY) inv_new = UNITY;
      start_new = ACC_W'(inv_new >> 1) - HALF;
   end

   // frame position and history pixels
   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         dst_col_ff <= '0;
         dst_row_ff <= '0;
         racc_ff    <= '0;
         cacc_ff    <= '0;
         left_ff    <= '0;
         aleft_ff   <= '0;
      end else if (csr_we) begin
         if (csr_hit) begin
            src_col_ff <= '0;
            src_row_ff <= '0;
            dst_col_ff <= '0;
            dst_row_ff <= '0;
            racc_ff    <= start_new;
            cacc_ff    <= start_new;
         end
      end else if (accept) begin
         if (restart_now) begin
            src_col_ff <= '0;
            src_row_ff <= '0;
            dst_col_ff <= '0;
            dst_row_ff <= '0;
            racc_ff    <= start;
            cacc_ff    <= start;
         end
      end else if (state_ff == S_MAP) begin
         aleft_ff <= rd_data;
         left_ff  <= pix_ff;
         if ({1'b0, src_col_ff} + WW'(1) < w) begin
            src_col_ff <= src_col_ff + 1'b1;
            dst_col_ff <= dst_col_ff + DIM_W'(ncols);
            cacc_ff    <= cacc_ff + (ncols[1] ? ACC_W'(inv) << 1
                                      : (ncols[0] ? ACC_W'(inv) : '0));
         end else if (DIM_W'(src_row_ff) + DIM_W'(1) < h) begin
            src_col_ff <= '0;
            src_row_ff <= src_row_ff + 1'b1;
            dst_col_ff <= '0;
            cacc_ff    <= start;
            dst_row_ff <= dst_row_ff + DIM_W'(nrows);
            racc_ff    <= racc_ff + (nrows[1] ? ACC_W'(inv) << 1
                                     : (nrows[0] ? ACC_W'(inv) : '0));
         end else begin
            src_col_ff <= '0;
            src_row_ff <= '0;
            dst_col_ff <= '0;
            dst_row_ff <= '0;
            racc_ff    <= start;
            cacc_ff    <= start;
         end
      end
   end

   // item payload and snapshot of the samples
   always_ff @(posedge clock) begin
      if (accept) pix_ff <= req_pix;
      if (state_ff == S_MAP) begin
         unity_q  <= unity;
         ulast_q  <= ({1'b0, src_col_ff} == w - 1'b1)
                     && (DIM_W'(src_row_ff) == h - 1'b1);
         above_q  <= rd_data;
         left_q   <= left_ff;
         aleft_q  <= aleft_ff;
         dc_q     <= dst_col_ff;
         dr_q     <= dst_row_ff;
         nrows_q  <= nrows - 1'b1;
         ncols_q  <= ncols - 1'b1;
         c_q      <= src_col_ff;
         r_q      <= src_row_ff;
         ty_q[0]  <= racc_ff[15 -: WB];
         ty_q[1]  <= rsum1[15 -: WB];
         tx_q[0]  <= cacc_ff[15 -: WB];
         tx_q[1]  <= csum1[15 -: WB];
         srow_q[0] <= (rm0.i0 == rm0.i1);
         srow_q[1] <= (rm1.i0 == rm1.i1);
         scol_q[0] <= (cm0.i0 == cm0.i1);
         scol_q[1] <= (cm1.i0 == cm1.i1);
      end
   end

   // output walk, rows outer and columns inner
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= 1'b0;
         b_ff <= 1'b0;
      end else if (state_ff == S_MAP) begin
         a_ff <= 1'b0;
         b_ff <= 1'b0;
      end else if (out_load && !item_done) begin
         if (b_ff == ncols_q[0]) begin
            b_ff <= 1'b0;
            a_ff <= 1'b1;
         end else begin
            b_ff <= 1'b1;
         end
      end
   end

   // sample selection at the image borders
   always_comb begin
      p11 = pix_ff;
      p10 = scol_q[b_ff] ? pix_ff : left_q;
      p01 = srow_q[a_ff] ? pix_ff : above_q;
      p00 = scol_q[b_ff] ? p01 : (srow_q[a_ff] ? left_q : aleft_q);
   end

   bd_line_mem #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIX_W)
   ) u_line (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (src_col_ff),
      .wr_data (pix_ff),
      .rd_en   (mem_re),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bd_blend #(
      .WEIGHT_BITS (WB)
   ) u_blend (
      .clock (clock),
      .load  (blend_load),
      .p00   (p00),
      .p01   (p01),
      .p10   (p10),
      .p11   (p11),
      .tx    (tx_q[b_ff]),
      .ty    (ty_q[a_ff]),
      .res   (blend_res)
   );

   // channel mask
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (k < int'(ch)) res_sel[k] = unity_q ? pix_ff[8*k +: 8] : blend_res[k];
         else res_sel[k] = 8'h00;
      end
   end

   // output register
   logic [DIM_W-1:0] oc, orow;
   assign oc   = dc_q + DIM_W'(b_ff);
   assign orow = dr_q + DIM_W'(a_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         res_ff        <= res_sel;
         col_ff        <= unity_q ? POS_W'(c_q) : oc[POS_W-1:0];
         row_ff        <= unity_q ? r_q : orow[POS_W-1:0];
         run_last_ff   <= item_done;
         frame_last_ff <= unity_q ? ulast_q
                          : ((orow == oh - 1'b1) && (oc == ow - 1'b1));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_res0       = res_ff[0];
   assign rsp_res1       = res_ff[1];
   assign rsp_res2       = res_ff[2];
   assign rsp_res3       = res_ff[3];
   assign rsp_out_col    = col_ff;
   assign rsp_out_row    = row_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_frame_last = frame_last_ff;

   // checks
   a_accept_map: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_MAP)
      else $error("accepted item did not enter mapping");

   a_frame_last_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_last_ff |-> run_last_ff)
      else $error("frame end is not the last result of its item");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HORZ || state_ff == S_VERT) && !unity_q
      |-> (a_ff <= nrows_q[0]) && (b_ff <= ncols_q[0]))
      else $error("output walk beyond the served rows or columns");

endmodule
